FILE: src/qte_pkg.sv
// Shared widths, constants, angle table and bundle types for the quaternion to Euler converter.
package qte_pkg;

    // Scaled products are Q.30 values held in 32 bits.
    localparam int PQ_W   = 32;
    // Sines and cosines reach magnitude 2^32, so they need 34 bits.
    localparam int SUM_W  = 34;
    // CORDIC vector width, with headroom for the gain of about 1.65.
    localparam int CW     = 38;
    localparam int ANG_W  = 32;
    localparam int OUT_W  = 16;
    // Square root of a value below 2^62: 31 result bits, one per cell.
    localparam int RAD_W  = 62;
    localparam int ROOT_W = 31;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SQ_W   = 64;

    localparam logic signed [SUM_W-1:0] ONE_Q30      = SUM_W'(64'sd1073741824);
    localparam logic signed [SUM_W-1:0] MINUS_ONE_Q30 = -ONE_Q30;
    localparam logic [RAD_W-2:0]        ONE_Q60      = (RAD_W-1)'(1) << 60;

    localparam logic [ANG_W-1:0] ANG_HALF_PI       = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_MINUS_HALF_PI = 32'hC000_0000;
    localparam logic [ANG_W-1:0] ANG_ROUND         = 32'h0000_8000;

    localparam logic signed [OUT_W-1:0] PITCH_MAX = 16'sd16384;
    localparam logic signed [OUT_W-1:0] PITCH_MIN = -16'sd16384;

    // atan(2^-i) with 2^31 standing for pi.
    localparam logic [ANG_W-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // The five trigonometric arguments and the pitch saturation flags.
    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
        logic signed [SUM_W-1:0] sinp;
        logic                    sat_pos;
        logic                    sat_neg;
    } t_side;

    // Status that rides beside the CORDIC lanes.
    typedef struct packed {
        logic [2:0] zero;
        logic       sat_pos;
        logic       sat_neg;
    } t_flags;

endpackage

FILE: src/qte_if.sv
// Stream interfaces for quaternion requests and Euler angle results.
interface qte_quat_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

FILE: src/qte_delay.sv
// Shift line that carries side data alongside the pipeline cells.
module qte_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_line[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

FILE: src/qte_sqrt_cell.sv
// One digit cell of the pipelined floor square root.
module qte_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [qte_pkg::RAD_W-1:0]  i_rad,
    input  logic [qte_pkg::REM_W-1:0]  i_rem,
    input  logic [qte_pkg::ROOT_W-1:0] i_root,
    output logic [qte_pkg::RAD_W-1:0]  o_rad,
    output logic [qte_pkg::REM_W-1:0]  o_rem,
    output logic [qte_pkg::ROOT_W-1:0] o_root
);

    logic [qte_pkg::REM_W-1:0] w_rem;
    logic [qte_pkg::REM_W-1:0] w_trial;
    logic                      w_ge;

    // Bring down the next two radicand bits and try to set the next root bit.
    assign w_rem   = {i_rem[qte_pkg::REM_W-3:0], i_rad[qte_pkg::RAD_W-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_rad  <= {i_rad[qte_pkg::RAD_W-3:0], 2'b00};
            o_rem  <= w_ge ? (w_rem - w_trial) : w_rem;
            o_root <= {i_root[qte_pkg::ROOT_W-2:0], w_ge};
        end
    end

endmodule

FILE: src/qte_cordic_cell.sv
// One vectoring CORDIC iteration with its output registers.
module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_adv,
    input  logic signed [qte_pkg::CW-1:0]  i_x,
    input  logic signed [qte_pkg::CW-1:0]  i_y,
    input  logic [qte_pkg::ANG_W-1:0]      i_z,
    output logic signed [qte_pkg::CW-1:0]  o_x,
    output logic signed [qte_pkg::CW-1:0]  o_y,
    output logic [qte_pkg::ANG_W-1:0]      o_z
);

    localparam logic [qte_pkg::ANG_W-1:0] ANG = qte_pkg::ATAN_TABLE[5'(STEP)];

    logic signed [qte_pkg::CW-1:0] w_dx;
    logic signed [qte_pkg::CW-1:0] w_dy;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    // Rotate toward the x axis: the sign of y picks the direction.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (!i_y[qte_pkg::CW-1]) begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + ANG;
            end else begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - ANG;
            end
        end
    end

endmodule

FILE: src/quaternion_to_euler_angles.sv
// Top level: pipelined quaternion to roll, pitch and yaw converter.
//
//  channel   | dir | payload                                            | handshake
//  ----------+-----+----------------------------------------------------+-------------
//  i_quat    | in  | quat_w, quat_x, quat_y, quat_z (signed Q1.(DW-1))  | valid/ready
//  o_euler   | out | roll_angle, pitch_angle, yaw_angle, pitch_clamped  | valid/ready
//
// One request enters per clock unless the pipeline stalls; every stage is a register, so
// throughput is one per cycle. The stages are products, sums, square, radicand, 31 square
// root cells, quadrant pre-rotation, CORDIC_STEPS CORDIC cells and the output register.
// The synchronous active-low reset clears only the valid bits; payload is not reset.
// The whole pipeline stalls only when the output register holds a result that is not
// taken and the last stage also holds one; otherwise requests keep flowing.
module quaternion_to_euler_angles #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);

    localparam int PQ_W   = qte_pkg::PQ_W;
    localparam int SUM_W  = qte_pkg::SUM_W;
    localparam int CW     = qte_pkg::CW;
    localparam int ANG_W  = qte_pkg::ANG_W;
    localparam int OUT_W  = qte_pkg::OUT_W;
    localparam int RAD_W  = qte_pkg::RAD_W;
    localparam int ROOT_W = qte_pkg::ROOT_W;
    localparam int REM_W  = qte_pkg::REM_W;
    localparam int SQ_W   = qte_pkg::SQ_W;

    // Products of two Q1.(DW-1) values carry 2*(DW-1) fraction bits; bring them to 30.
    localparam int SHIFT   = 2 * (DATA_WIDTH - 1) - 30;
    localparam int SHIFT_R = (SHIFT > 0) ? SHIFT : 0;
    localparam int SHIFT_L = (SHIFT < 0) ? -SHIFT : 0;

    // Stages: products, sums, square, radicand, root cells, pre-rotation, CORDIC cells.
    localparam int N_PIPE  = 4 + ROOT_W + 1 + CORDIC_STEPS;

    function automatic logic signed [PQ_W-1:0] q30(input logic signed [DATA_WIDTH-1:0] a,
                                                   input logic signed [DATA_WIDTH-1:0] b);
        logic signed [2*DATA_WIDTH-1:0] p;
        logic signed [63:0]             e;
        p = a * b;
        e = 64'(p);
        e = (e >>> SHIFT_R) <<< SHIFT_L;
        return e[PQ_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [PQ_W-1:0] v);
        return SUM_W'(v);
    endfunction

    // ---------------------------------------------------------------- flow control
    logic              w_adv;
    logic              w_stall;
    logic              w_load;
    logic [N_PIPE-1:0] r_vld;
    logic              r_out_valid;

    assign w_stall      = r_out_valid && !o_euler.ready && r_vld[N_PIPE-1];
    assign w_adv        = !w_stall;
    assign w_load       = w_adv && r_vld[N_PIPE-1];
    assign i_quat.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[N_PIPE-2:0], i_quat.valid};
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_euler.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- products
    logic signed [PQ_W-1:0] r_xx, r_yy, r_zz, r_wx, r_yz, r_wy, r_zx, r_wz, r_xy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx <= q30(i_quat.quat_x, i_quat.quat_x);
            r_yy <= q30(i_quat.quat_y, i_quat.quat_y);
            r_zz <= q30(i_quat.quat_z, i_quat.quat_z);
            r_wx <= q30(i_quat.quat_w, i_quat.quat_x);
            r_yz <= q30(i_quat.quat_y, i_quat.quat_z);
            r_wy <= q30(i_quat.quat_w, i_quat.quat_y);
            r_zx <= q30(i_quat.quat_z, i_quat.quat_x);
            r_wz <= q30(i_quat.quat_w, i_quat.quat_z);
            r_xy <= q30(i_quat.quat_x, i_quat.quat_y);
        end
    end

    // ---------------------------------------------------------------- sums
    qte_pkg::t_side n_side;
    qte_pkg::t_side r_side;

    always_comb begin
        n_side.sinr    = (ext(r_wx) + ext(r_yz)) <<< 1;
        n_side.cosr    = qte_pkg::ONE_Q30 - ((ext(r_xx) + ext(r_yy)) <<< 1);
        n_side.sinp    = (ext(r_wy) - ext(r_zx)) <<< 1;
        n_side.siny    = (ext(r_wz) + ext(r_xy)) <<< 1;
        n_side.cosy    = qte_pkg::ONE_Q30 - ((ext(r_yy) + ext(r_zz)) <<< 1);
        n_side.sat_pos = (n_side.sinp >= qte_pkg::ONE_Q30);
        n_side.sat_neg = (n_side.sinp <= qte_pkg::MINUS_ONE_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side <= n_side;
        end
    end

    // ---------------------------------------------------------------- cos(pitch) radicand
    // The square only matters when |sinp| < 1, where the low 32 bits hold it exactly.
    logic signed [SQ_W-1:0]  r_sq;
    logic [RAD_W-1:0]        r_rad;
    logic signed [PQ_W-1:0]  w_sinp_lo;

    assign w_sinp_lo = r_side.sinp[PQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq  <= w_sinp_lo * w_sinp_lo;
            r_rad <= {1'b0, qte_pkg::ONE_Q60 - r_sq[RAD_W-2:0]};
        end
    end

    // ---------------------------------------------------------------- square root cells
    logic [RAD_W-1:0]  w_rad  [ROOT_W+1];
    logic [REM_W-1:0]  w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_root [ROOT_W+1];

    assign w_rad[0]  = r_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_rad  (w_rad[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_rad  (w_rad[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    // Sines, cosines and flags wait beside the square root.
    qte_pkg::t_side w_side_d;

    qte_delay #(
        .WIDTH ($bits(qte_pkg::t_side)),
        .DEPTH (2 + ROOT_W)
    ) u_side_delay (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_data (r_side),
        .o_data (w_side_d)
    );

    // ---------------------------------------------------------------- pre-rotation
    // Lanes: 0 roll, 1 pitch, 2 yaw. A vector in the left half plane is turned by
    // a quarter turn first; the zero vector is flagged and gives angle zero.
    logic signed [CW-1:0] w_in_x [3];
    logic signed [CW-1:0] w_in_y [3];
    logic signed [CW-1:0] r_px   [3];
    logic signed [CW-1:0] r_py   [3];
    logic [ANG_W-1:0]     r_pz   [3];
    qte_pkg::t_flags      n_flags;
    qte_pkg::t_flags      r_pflags;

    assign w_in_x[0] = CW'(w_side_d.cosr);
    assign w_in_y[0] = CW'(w_side_d.sinr);
    assign w_in_x[1] = CW'({1'b0, w_root[ROOT_W]});
    assign w_in_y[1] = CW'(w_side_d.sinp);
    assign w_in_x[2] = CW'(w_side_d.cosy);
    assign w_in_y[2] = CW'(w_side_d.siny);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_flags.zero[l] = (w_in_x[l] == '0) && (w_in_y[l] == '0);
        end
        n_flags.sat_pos = w_side_d.sat_pos;
        n_flags.sat_neg = w_side_d.sat_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pflags <= n_flags;
            for (int l = 0; l < 3; l++) begin
                if (!w_in_x[l][CW-1]) begin
                    r_px[l] <= w_in_x[l];
                    r_py[l] <= w_in_y[l];
                    r_pz[l] <= '0;
                end else if (!w_in_y[l][CW-1]) begin
                    r_px[l] <= w_in_y[l];
                    r_py[l] <= -w_in_x[l];
                    r_pz[l] <= qte_pkg::ANG_HALF_PI;
                end else begin
                    r_px[l] <= -w_in_y[l];
                    r_py[l] <= w_in_x[l];
                    r_pz[l] <= qte_pkg::ANG_MINUS_HALF_PI;
                end
            end
        end
    end

    // ---------------------------------------------------------------- CORDIC lanes
    logic signed [CW-1:0] w_cx [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] w_cy [3][CORDIC_STEPS+1];
    logic [ANG_W-1:0]     w_cz [3][CORDIC_STEPS+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_cx[l][0] = r_px[l];
        assign w_cy[l][0] = r_py[l];
        assign w_cz[l][0] = r_pz[l];
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
            qte_cordic_cell #(
                .STEP (s % 32)
            ) u_cell (
                .i_clk (i_clk),
                .i_adv (w_adv),
                .i_x   (w_cx[l][s]),
                .i_y   (w_cy[l][s]),
                .i_z   (w_cz[l][s]),
                .o_x   (w_cx[l][s+1]),
                .o_y   (w_cy[l][s+1]),
                .o_z   (w_cz[l][s+1])
            );
        end
    end

    qte_pkg::t_flags w_flags_d;

    qte_delay #(
        .WIDTH ($bits(qte_pkg::t_flags)),
        .DEPTH (CORDIC_STEPS)
    ) u_flag_delay (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_data (r_pflags),
        .o_data (w_flags_d)
    );

    // ---------------------------------------------------------------- rounding and output
    logic [ANG_W-1:0]        w_rz   [3];
    logic signed [OUT_W-1:0] w_ang  [3];
    logic signed [OUT_W-1:0] w_pitch;
    logic signed [OUT_W-1:0] r_roll;
    logic signed [OUT_W-1:0] r_pitch;
    logic signed [OUT_W-1:0] r_yaw;
    logic                    r_clamped;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_rz[l]  = w_cz[l][CORDIC_STEPS] + qte_pkg::ANG_ROUND;
            w_ang[l] = w_flags_d.zero[l] ? '0 : w_rz[l][ANG_W-1 -: OUT_W];
        end
        if (w_flags_d.sat_pos) begin
            w_pitch = qte_pkg::PITCH_MAX;
        end else if (w_flags_d.sat_neg) begin
            w_pitch = qte_pkg::PITCH_MIN;
        end else if (w_ang[1] > qte_pkg::PITCH_MAX) begin
            w_pitch = qte_pkg::PITCH_MAX;
        end else if (w_ang[1] < qte_pkg::PITCH_MIN) begin
            w_pitch = qte_pkg::PITCH_MIN;
        end else begin
            w_pitch = w_ang[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_roll    <= w_ang[0];
            r_pitch   <= w_pitch;
            r_yaw     <= w_ang[2];
            r_clamped <= w_flags_d.sat_pos || w_flags_d.sat_neg;
        end
    end

    assign o_euler.valid         = r_out_valid;
    assign o_euler.roll_angle    = r_roll;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.yaw_angle     = r_yaw;
    assign o_euler.pitch_clamped = r_clamped;

    // ---------------------------------------------------------------- assertions
    // A saturated pitch is exactly a quarter turn.
    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_euler.valid && o_euler.pitch_clamped) |->
            (o_euler.pitch_angle == qte_pkg::PITCH_MAX ||
             o_euler.pitch_angle == qte_pkg::PITCH_MIN))
        else $error("clamped pitch is not a quarter turn");

    // Pitch never leaves the closed range of plus or minus a quarter turn.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |->
            (o_euler.pitch_angle <= qte_pkg::PITCH_MAX &&
             o_euler.pitch_angle >= qte_pkg::PITCH_MIN))
        else $error("pitch out of range");

    // Requests are refused only while a held result blocks the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_quat.ready |-> (o_euler.valid && !o_euler.ready))
        else $error("input stalled without output back-pressure");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_euler.valid)
        else $error("result valid after reset");

endmodule

FILE: dv/tb_quaternion_to_euler_angles.sv
// Testbench for the quaternion to Euler angle converter: a self-checking stream test.
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles;

    localparam int DW        = 16;
    localparam int STEPS     = 16;
    // Pipeline latency of the top level.
    localparam int LATENCY   = 37 + STEPS;
    localparam int N_RANDOM  = 1700;
    localparam int LONG_HOLD = 200;

    // One quaternion request and one set of Euler angles.
    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    logic i_clk;
    logic i_rst_n;

    qte_quat_if #(.DATA_WIDTH(DW)) quat_bus ();
    qte_euler_if                   euler_bus ();

    quaternion_to_euler_angles #(
        .DATA_WIDTH  (DW),
        .CORDIC_STEPS(STEPS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quat (quat_bus.sink),
        .o_euler(euler_bus.source)
    );

    // Requests waiting to be driven, and angle sets still owed by the block.
    t_quat  pending_quats[$];
    t_euler owed_angles[$];

    int  mismatch_count = 0;
    // When set, the driver offers nothing until every owed result has come back.
    bit  drain_request  = 0;
    // When set, the receiver holds ready low for a long stretch.
    bit  hold_request   = 0;

    // ------------------------------------------------------------------
    // Predictor: the fixed-point arithmetic of the converter.
    // ------------------------------------------------------------------

    // Product of two Q1.15 components brought to Q.30 (flooring shift).
    function automatic longint q30_product(longint a, longint b);
        longint p;
        p = a * b;
        if (2 * (DW - 1) >= 30)
            return p >>> (2 * (DW - 1) - 30);
        return p <<< (30 - 2 * (DW - 1));
    endfunction

    // Vectoring CORDIC; 2^31 in the 32-bit accumulator stands for pi.
    function automatic logic [31:0] cordic_angle(longint y, longint x);
        logic [31:0] acc;
        longint      t;
        longint      dx;
        longint      dy;
        acc = '0;
        if (x == 0 && y == 0)
            return '0;
        // Rotate left-half-plane vectors by a quarter turn first.
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; acc = qte_pkg::ANG_HALF_PI;
            end else begin
                t = -y; y = x; x = t; acc = qte_pkg::ANG_MINUS_HALF_PI;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += qte_pkg::ATAN_TABLE[i];
            end else begin
                x -= dx; y += dy; acc -= qte_pkg::ATAN_TABLE[i];
            end
        end
        return acc;
    endfunction

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Round the accumulator to a 16-bit binary angle; wraps at +pi.
    function automatic logic [15:0] binary_angle(logic [31:0] acc);
        logic [31:0] r;
        r = acc + qte_pkg::ANG_ROUND;
        return r[31:16];
    endfunction

    function automatic t_euler euler_from_quat(t_quat q);
        longint      w, x, y, z;
        longint      xx, yy, zz;
        longint      sinr, cosr, sinp, siny, cosy;
        longint      root;
        longint      sp;
        logic [15:0] p16;
        t_euler      e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        xx = q30_product(x, x);
        yy = q30_product(y, y);
        zz = q30_product(z, z);
        sinr = 2 * (q30_product(w, x) + q30_product(y, z));
        cosr = (64'sd1 << 30) - 2 * (xx + yy);
        sinp = 2 * (q30_product(w, y) - q30_product(z, x));
        siny = 2 * (q30_product(w, z) + q30_product(x, y));
        cosy = (64'sd1 << 30) - 2 * (yy + zz);
        e.clamped = 1'b0;
        if (sinp >= (64'sd1 << 30)) begin
            e.pitch   = qte_pkg::PITCH_MAX;
            e.clamped = 1'b1;
        end else if (sinp <= -(64'sd1 << 30)) begin
            e.pitch   = qte_pkg::PITCH_MIN;
            e.clamped = 1'b1;
        end else begin
            // Pitch is asin(s) taken as atan2(s, sqrt(1 - s*s)).
            root = longint'(floor_sqrt((64'd1 << 60) - longint'(sinp * sinp)));
            p16  = binary_angle(cordic_angle(sinp, root));
            sp   = longint'($signed(p16));
            // CORDIC error past a quarter turn is saturated silently.
            if (sp > 16384)  sp = 16384;
            if (sp < -16384) sp = -16384;
            e.pitch = 16'(sp);
        end
        e.roll = binary_angle(cordic_angle(sinr, cosr));
        e.yaw  = binary_angle(cordic_angle(siny, cosy));
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and time limit.
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Worst case is far below this: each request waits at most a long sender
    // gap plus a long receiver stall, and the pipeline latency once.
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: takes requests from the pending queue, with random gaps.
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int  send_gap = 0;
    bit  draining = 0;
    bit  burst_mode = 0;
    int  burst_left = 0;

    always @(posedge i_clk) begin
        t_quat q;
        if (!i_rst_n) begin
            quat_bus.valid  <= 1'b0;
            quat_bus.quat_w <= '0;
            quat_bus.quat_x <= '0;
            quat_bus.quat_y <= '0;
            quat_bus.quat_z <= '0;
        end else begin
            // A request that is offered stays put until it is accepted.
            if (!quat_bus.valid || quat_bus.ready) begin
                if (quat_bus.valid && quat_bus.ready)
                    void'(pending_quats.pop_front());
                if (drain_request && !draining)
                    draining = 1;
                if (draining && owed_angles.size() == 0 &&
                        !(quat_bus.valid && quat_bus.ready)) begin
                    draining = 0;
                    drain_request = 0;
                end
                // Now and then a stretch without gaps comes between gappy stretches.
                if (burst_left == 0) begin
                    burst_mode = $urandom_range(0, 3) == 0;
                    burst_left = $urandom_range(20, 120);
                end else begin
                    burst_left--;
                end
                if (send_gap > 0) send_gap--;
                if (!draining && send_gap == 0 && pending_quats.size() > 0) begin
                    q = pending_quats[0];
                    quat_bus.valid  <= 1'b1;
                    quat_bus.quat_w <= q.w;
                    quat_bus.quat_x <= q.x;
                    quat_bus.quat_y <= q.y;
                    quat_bus.quat_z <= q.z;
                    if (!burst_mode) send_gap = random_gap();
                end else begin
                    quat_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Predict at acceptance, so the owed queue matches the block's order.
    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n && quat_bus.valid && quat_bus.ready) begin
            q.w = quat_bus.quat_w;
            q.x = quat_bus.quat_x;
            q.y = quat_bus.quat_y;
            q.z = quat_bus.quat_z;
            owed_angles.push_back(euler_from_quat(q));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off counted in cycles.
    // ------------------------------------------------------------------

    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            euler_bus.ready <= 1'b0;
        end else begin
            if (hold_request && hold_left == 0) begin
                hold_left    = LONG_HOLD;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                euler_bus.ready <= 1'b0;
            end else if (burst_mode) begin
                euler_bus.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                // A rare longer pause on the receiving side.
                hold_left = $urandom_range(10, 40);
                euler_bus.ready <= 1'b0;
            end else begin
                euler_bus.ready <= ($urandom_range(0, 99) < 70) ||
                                   ($urandom_range(0, 99) < 50);
            end
        end
    end

    // Monitor: compare each result with the oldest owed angle set.
    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && euler_bus.valid && euler_bus.ready) begin
            if (owed_angles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing owed: roll %0d pitch %0d yaw %0d",
                             $realtime, euler_bus.roll_angle, euler_bus.pitch_angle,
                             euler_bus.yaw_angle);
            end else begin
                want = owed_angles.pop_front();
                if (euler_bus.roll_angle !== want.roll ||
                        euler_bus.pitch_angle !== want.pitch ||
                        euler_bus.yaw_angle !== want.yaw ||
                        euler_bus.pitch_clamped !== want.clamped) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch: expected roll %0d pitch %0d yaw %0d ",
                                  "clamp %0b, got roll %0d pitch %0d yaw %0d clamp %0b"},
                                 $realtime, want.roll, want.pitch, want.yaw,
                                 want.clamped, euler_bus.roll_angle,
                                 euler_bus.pitch_angle, euler_bus.yaw_angle,
                                 euler_bus.pitch_clamped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // A random unit quaternion: random components scaled to norm near one.
    function automatic t_quat unit_quat();
        real   c[4];
        real   n;
        t_quat q;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            c[i] = real'($signed(16'($urandom)));
            n += c[i] * c[i];
        end
        if (n == 0.0) begin
            c[0] = 1.0; n = 1.0;
        end
        n = $sqrt(n);
        q.w = 16'($rtoi(c[0] / n * 32767.0));
        q.x = 16'($rtoi(c[1] / n * 32767.0));
        q.y = 16'($rtoi(c[2] / n * 32767.0));
        q.z = 16'($rtoi(c[3] / n * 32767.0));
        return q;
    endfunction

    function automatic t_quat make_quat(int w, int x, int y, int z);
        t_quat q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    initial begin
        t_quat q;
        int    r;
        int    settle;

        // Directed requests: identity, extremes of every field, gimbal lock
        // on both sides (pitch saturates), near-lock, zero vector and
        // angles at +pi where the output wraps.
        pending_quats.push_back(make_quat(32767, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(-32768, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 32767, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 32767, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 32767));
        pending_quats.push_back(make_quat(0, -32768, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, -32768));
        pending_quats.push_back(make_quat(23170, 0, 23170, 0));
        pending_quats.push_back(make_quat(23170, 0, -23170, 0));
        pending_quats.push_back(make_quat(23170, 23170, 23170, -23170));
        pending_quats.push_back(make_quat(23170, -23170, -23170, -23170));
        pending_quats.push_back(make_quat(23169, 0, 23169, 0));
        pending_quats.push_back(make_quat(23171, 0, -23171, 0));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(1, -1, 1, -1));
        pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(23170, 23170, 0, 0));
        pending_quats.push_back(make_quat(23170, 0, 0, 23170));

        @(posedge i_clk);
        wait (i_rst_n === 1'b1);

        // Mostly unit quaternions, some near gimbal lock, some raw bit noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                q = unit_quat();
            end else if (r < 80) begin
                // Near gimbal lock: w close to y (or -y), z equal to x (or -x).
                q.w = 16'($urandom_range(22000, 24000));
                q.y = ($urandom_range(0, 1) ? q.w : -q.w) +
                      16'($signed($urandom_range(0, 40)) - 20);
                q.x = 16'($signed($urandom_range(0, 400)) - 200);
                q.z = ($urandom_range(0, 1) ? q.x : -q.x);
            end else begin
                q.w = 16'($urandom); q.x = 16'($urandom);
                q.y = 16'($urandom); q.z = 16'($urandom);
            end
            pending_quats.push_back(q);

            // Fill the pipeline against a stopped receiver once.
            if (n == 300) hold_request = 1;
            // Let the pipeline run dry once before continuing.
            if (n == 900) drain_request = 1;
            if (pending_quats.size() > 64)
                wait (pending_quats.size() < 32);
        end

        wait (pending_quats.size() == 0);
        wait (!quat_bus.valid);
        settle = 0;
        while (owed_angles.size() != 0 && settle < 100000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0 && owed_angles.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
